@@ hw/rtl/mcqp_pkg.sv @@
package mcqp_pkg;

  // Field widths
  localparam int VAL_W     = 32;
  localparam int CODE_W    = 16;
  localparam int ID_W      = 8;
  localparam int MODE_W    = 5;
  localparam int FRAME_W   = MODE_W + CODE_W + ID_W;
  localparam int PAYLOAD_W = 4 * CODE_W;

  // Quantizer arithmetic widths
  localparam int NUM_W  = VAL_W + CODE_W;       // (x - low) * 65535
  localparam int DVD_W  = NUM_W + 1;            // 2 * num + den, stays below 2^49
  localparam int DVSR_W = VAL_W + 1;            // 2 * den

  // Pipeline shape
  localparam int PREP_STAGES = 3;
  localparam int DIV_STAGES  = CODE_W;
  localparam int PIPE_DEPTH  = PREP_STAGES + DIV_STAGES;

  // Frame constants
  localparam logic [MODE_W-1:0] FRAME_MODE = MODE_W'(1);
  localparam logic [ID_W-1:0]   CALF_JOINT = ID_W'(3);
  localparam logic [ID_W-1:0]   JOINTS_PER_LEG = ID_W'(10);
  // id / 10 == (id * 205) >> 11 for every 8-bit id
  localparam logic [15:0]       JOINT_RECIP = 16'd205;
  localparam int                JOINT_RECIP_SHIFT = 11;

  // Configuration port
  localparam int CFG_IDX_W = 8;
  localparam int REG_IDX_W = 3;
  localparam int NUM_REGS  = 2 ** REG_IDX_W;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_POS_LOW,
    REG_POS_HIGH,
    REG_VEL_LOW,
    REG_VEL_HIGH,
    REG_TORQUE_LOW,
    REG_TORQUE_HIGH,
    REG_CALF_TORQUE_LOW,
    REG_CALF_TORQUE_HIGH
  } cfg_reg_e;

  localparam logic signed [VAL_W-1:0] CFG_RESET [NUM_REGS] = '{
    -32'sd823550,  32'sd823550,
    -32'sd2883584, 32'sd2883584,
    -32'sd1114112, 32'sd1114112,
    -32'sd1114112, 32'sd1114112
  };

  // Calf joints are those whose id mod 10 is 3.
  function automatic logic is_calf(logic [ID_W-1:0] id);
    logic [15:0]     prod;
    logic [ID_W-1:0] quot;
    logic [ID_W-1:0] rem;
    prod = 16'(id) * JOINT_RECIP;
    quot = ID_W'(prod >> JOINT_RECIP_SHIFT);
    rem  = id - ID_W'(quot * JOINTS_PER_LEG);
    return rem == CALF_JOINT;
  endfunction

endpackage

@@ hw/rtl/mcqp_if.sv @@
interface mcqp_cmd_if import mcqp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] pos_target;
  logic signed [VAL_W-1:0] vel_target;
  logic signed [VAL_W-1:0] stiffness_gain;
  logic signed [VAL_W-1:0] damping_gain;
  logic signed [VAL_W-1:0] torque_ff;
  logic [ID_W-1:0]         actuator_id;

  modport source (output valid, pos_target, vel_target, stiffness_gain, damping_gain,
                  torque_ff, actuator_id, input ready);
  modport sink   (input valid, pos_target, vel_target, stiffness_gain, damping_gain,
                  torque_ff, actuator_id, output ready);
endinterface

interface mcqp_res_if import mcqp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FRAME_W-1:0]   frame_id;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, frame_id, payload, input ready);
  modport sink   (input valid, frame_id, payload, output ready);
endinterface

interface mcqp_cfg_if import mcqp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/motor_command_quantize_pack.sv @@
// Motor command quantizer and packer.
// cmd_i carries one request per motor command: position, velocity, stiffness,
// damping and feed-forward torque (signed Q16.16) plus an 8-bit motor id.
// Each value is clamped to its range and mapped onto 0..65535, rounding half up;
// an empty or inverted range yields code 0. Calf joints (id mod 10 == 3) use the
// calf torque range. res_o returns one request per command: a 29-bit frame id
// (mode, torque code, motor id) and the 64-bit big-endian payload.
// cfg_i writes the eight range registers by index; indexes past the list are
// dropped. Write them only while no command is in flight. cfg_i is always ready.
// Throughput: one command per cycle unless res_o stalls with every stage full.
// A command passes 19 register stages: three of clamp and scale, then a 16-stage
// restoring divider that resolves one quotient bit per stage for all five values.
// Reset clears the pipeline valid bits and loads the default ranges.
// When res_o stalls, the last stage holds its result; earlier stages keep
// advancing into bubbles, and cmd_i.ready drops only once every stage is full.
module motor_command_quantize_pack import mcqp_pkg::*; #(
  parameter logic signed [31:0] STIFF_MIN = 32'sd0,
  parameter logic signed [31:0] STIFF_MAX = 32'sd327680000,
  parameter logic signed [31:0] DAMP_MIN  = 32'sd0,
  parameter logic signed [31:0] DAMP_MAX  = 32'sd6553600
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcqp_cmd_if.sink   cmd_i,
  mcqp_cfg_if.sink   cfg_i,
  mcqp_res_if.source res_o
);

  localparam int LANE_POS   = 0;
  localparam int LANE_VEL   = 1;
  localparam int LANE_STIFF = 2;
  localparam int LANE_DAMP  = 3;
  localparam int LANE_TORQ  = 4;
  localparam int NUM_LANES  = 5;
  localparam int LAST       = PIPE_DEPTH - 1;

  logic signed [VAL_W-1:0] cfg_q [NUM_REGS];

  logic [PIPE_DEPTH-1:0]   vld_q;
  logic [PIPE_DEPTH-1:0]   en;
  logic [ID_W-1:0]         id_q [PIPE_DEPTH];
  logic                    calf;
  logic                    in_fire, out_fire;

  logic signed [VAL_W-1:0] lane_x  [NUM_LANES];
  logic signed [VAL_W-1:0] lane_lo [NUM_LANES];
  logic signed [VAL_W-1:0] lane_hi [NUM_LANES];
  logic [CODE_W-1:0]       lane_code [NUM_LANES];

  // Range registers; drop writes past the register list
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= CFG_RESET[i];
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_W'(NUM_REGS))) begin
      cfg_q[cfg_reg_e'(cfg_i.index[REG_IDX_W-1:0])] <= cfg_i.data;
    end
  end

  // A stage advances when it or any stage after it holds a bubble, or the
  // output is being taken. No dependent ripple: each enable is one reduction.
  for (genvar s = 0; s < PIPE_DEPTH; s++) begin : g_en
    assign en[s] = res_o.ready || !(&vld_q[LAST:s]);
  end

  assign cmd_i.ready = en[0];
  assign in_fire     = cmd_i.valid && cmd_i.ready;
  assign out_fire    = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= cmd_i.valid;
      for (int s = 1; s < PIPE_DEPTH; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Motor id travels alongside the codes
  always_ff @(posedge clk_i) begin
    if (en[0]) id_q[0] <= cmd_i.actuator_id;
    for (int s = 1; s < PIPE_DEPTH; s++) begin
      if (en[s]) id_q[s] <= id_q[s-1];
    end
  end

  // Lane operands
  assign calf = is_calf(cmd_i.actuator_id);

  always_comb begin
    lane_x[LANE_POS]   = cmd_i.pos_target;
    lane_lo[LANE_POS]  = cfg_q[REG_POS_LOW];
    lane_hi[LANE_POS]  = cfg_q[REG_POS_HIGH];
    lane_x[LANE_VEL]   = cmd_i.vel_target;
    lane_lo[LANE_VEL]  = cfg_q[REG_VEL_LOW];
    lane_hi[LANE_VEL]  = cfg_q[REG_VEL_HIGH];
    lane_x[LANE_STIFF] = cmd_i.stiffness_gain;
    lane_lo[LANE_STIFF] = STIFF_MIN;
    lane_hi[LANE_STIFF] = STIFF_MAX;
    lane_x[LANE_DAMP]  = cmd_i.damping_gain;
    lane_lo[LANE_DAMP] = DAMP_MIN;
    lane_hi[LANE_DAMP] = DAMP_MAX;
    lane_x[LANE_TORQ]  = cmd_i.torque_ff;
    lane_lo[LANE_TORQ] = calf ? cfg_q[REG_CALF_TORQUE_LOW]  : cfg_q[REG_TORQUE_LOW];
    lane_hi[LANE_TORQ] = calf ? cfg_q[REG_CALF_TORQUE_HIGH] : cfg_q[REG_TORQUE_HIGH];
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic [DVD_W-1:0]  dvd;
    logic [DVSR_W-1:0] dvsr;

    mcqp_prep u_prep (
      .clk_i  (clk_i),
      .en_i   (en[PREP_STAGES-1:0]),
      .x_i    (lane_x[l]),
      .lo_i   (lane_lo[l]),
      .hi_i   (lane_hi[l]),
      .dvd_o  (dvd),
      .dvsr_o (dvsr)
    );

    mcqp_div u_div (
      .clk_i  (clk_i),
      .en_i   (en[LAST:PREP_STAGES]),
      .dvd_i  (dvd),
      .dvsr_i (dvsr),
      .quo_o  (lane_code[l])
    );
  end

  // Last divider stage doubles as the output register
  assign res_o.valid    = vld_q[LAST];
  assign res_o.frame_id = {FRAME_MODE, lane_code[LANE_TORQ], id_q[LAST]};
  assign res_o.payload  = {lane_code[LANE_POS], lane_code[LANE_VEL],
                           lane_code[LANE_STIFF], lane_code[LANE_DAMP]};

`ifndef SYNTHESIS
  // A bubble anywhere in the pipe must open the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&vld_q) |-> cmd_i.ready)
    else $error("input stalled with a free pipeline stage");

  // Occupancy holds when requests enter and leave in balance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire == out_fire) |=> $countones(vld_q) == $past($countones(vld_q)))
    else $error("pipeline lost or duplicated a request");

  // Occupancy grows by one on a lone input request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_fire) |=> $countones(vld_q) == $past($countones(vld_q)) + 1)
    else $error("accepted request not tracked");

  // Frame mode field is fixed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.frame_id[FRAME_W-1:FRAME_W-MODE_W] == FRAME_MODE)
    else $error("bad frame mode");
`endif

endmodule

@@ hw/rtl/mcqp_prep.sv @@
// Clamp, scale by 65535 and build the rounding dividend; three register stages.
module mcqp_prep import mcqp_pkg::*; (
  input  logic                    clk_i,
  input  logic [PREP_STAGES-1:0]  en_i,
  input  logic signed [VAL_W-1:0] x_i,
  input  logic signed [VAL_W-1:0] lo_i,
  input  logic signed [VAL_W-1:0] hi_i,
  output logic [DVD_W-1:0]        dvd_o,
  output logic [DVSR_W-1:0]       dvsr_o
);

  logic [VAL_W:0]    diff_q, span_q;
  logic [VAL_W-1:0]  clamp;
  logic              empty;
  logic [NUM_W-1:0]  num_d, num_q;
  logic [VAL_W-1:0]  den_d, den_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DVSR_W-1:0] dvsr_q;

  // Stage 2: clamp to [0, span] and multiply by 65535 as a shift and subtract
  always_comb begin
    empty = span_q[VAL_W] || (span_q == '0);
    if (diff_q[VAL_W]) begin
      clamp = '0;
    end else if (diff_q > span_q) begin
      clamp = span_q[VAL_W-1:0];
    end else begin
      clamp = diff_q[VAL_W-1:0];
    end
    if (empty) begin
      num_d = '0;
      den_d = VAL_W'(1);
    end else begin
      num_d = {clamp, CODE_W'(0)} - NUM_W'(clamp);
      den_d = span_q[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      diff_q <= {x_i[VAL_W-1], x_i} - {lo_i[VAL_W-1], lo_i};
      span_q <= {hi_i[VAL_W-1], hi_i} - {lo_i[VAL_W-1], lo_i};
    end
    if (en_i[1]) begin
      num_q <= num_d;
      den_q <= den_d;
    end
    if (en_i[2]) begin
      dvd_q  <= {num_q, 1'b0} + DVD_W'(den_q);
      dvsr_q <= {den_q, 1'b0};
    end
  end

  assign dvd_o  = dvd_q;
  assign dvsr_o = dvsr_q;

endmodule

@@ hw/rtl/mcqp_div.sv @@
// Restoring divider, one quotient bit per register stage.
module mcqp_div import mcqp_pkg::*; (
  input  logic                    clk_i,
  input  logic [DIV_STAGES-1:0]   en_i,
  input  logic [DVD_W-1:0]        dvd_i,
  input  logic [DVSR_W-1:0]       dvsr_i,
  output logic [CODE_W-1:0]       quo_o
);

  typedef struct packed {
    logic [DVSR_W-1:0] rem;
    logic [CODE_W-1:0] dvd_lo;
    logic [CODE_W-1:0] quo;
    logic [DVSR_W-1:0] dvsr;
  } stage_t;

  function automatic stage_t div_step(stage_t s);
    logic [DVSR_W:0] trial;
    logic            ge;
    stage_t          r;
    trial    = {s.rem, s.dvd_lo[CODE_W-1]};
    ge       = trial >= {1'b0, s.dvsr};
    r.rem    = ge ? DVSR_W'(trial - {1'b0, s.dvsr}) : trial[DVSR_W-1:0];
    r.dvd_lo = {s.dvd_lo[CODE_W-2:0], 1'b0};
    r.quo    = {s.quo[CODE_W-2:0], ge};
    r.dvsr   = s.dvsr;
    return r;
  endfunction

  stage_t init;
  stage_t st_q [DIV_STAGES];

  // Quotient fits 16 bits, so the upper dividend bits already sit below the divisor
  always_comb begin
    init.rem    = dvd_i[DVD_W-1:CODE_W];
    init.dvd_lo = dvd_i[CODE_W-1:0];
    init.quo    = '0;
    init.dvsr   = dvsr_i;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i[k]) st_q[k] <= div_step(init);
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i[k]) st_q[k] <= div_step(st_q[k-1]);
      end
    end
  end

  assign quo_o = st_q[DIV_STAGES-1].quo;

endmodule

@@ tb/sv/motor_command_quantize_pack_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the motor command quantizer and packer.
// Drive commands on cmd_if, range writes on cfg_if, and collect frames on res_if.
// Every accepted command request is run through a local quantizer and packer,
// and the frame it predicts is queued; each frame the block returns is popped
// and compared field by field.
module motor_command_quantize_pack_tb;
  import mcqp_pkg::*;

  // Stiffness and damping ranges, fixed at build time; hand the same values to the block.
  localparam logic signed [VAL_W-1:0] STIFF_LO = 32'sd0;
  localparam logic signed [VAL_W-1:0] STIFF_HI = 32'sd327680000;
  localparam logic signed [VAL_W-1:0] DAMP_LO  = 32'sd0;
  localparam logic signed [VAL_W-1:0] DAMP_HI  = 32'sd6553600;

  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

  localparam int CODE_TOP    = 65535;
  localparam int IDLE_MAX    = 13;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [VAL_W-1:0] pos;
    logic signed [VAL_W-1:0] vel;
    logic signed [VAL_W-1:0] stiff;
    logic signed [VAL_W-1:0] damp;
    logic signed [VAL_W-1:0] torque;
    logic [ID_W-1:0]         id;
  } motor_cmd_t;

  typedef struct packed {
    logic [FRAME_W-1:0]   frame_id;
    logic [PAYLOAD_W-1:0] payload;
  } can_frame_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mcqp_cmd_if cmd_if ();
  mcqp_cfg_if cfg_if ();
  mcqp_res_if res_if ();

  motor_command_quantize_pack #(
    .STIFF_MIN (STIFF_LO),
    .STIFF_MAX (STIFF_HI),
    .DAMP_MIN  (DAMP_LO),
    .DAMP_MAX  (DAMP_HI)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the eight range registers, indexed by register name.
  logic signed [VAL_W-1:0] range_reg [NUM_REGS];
  // Frames predicted for accepted commands, oldest first.
  can_frame_t pending_frames [$];

  int n_errors     = 0;
  int n_sent       = 0;
  int n_checked    = 0;
  int n_cfg_writes = 0;
  int n_in_stalls  = 0;
  int n_calf       = 0;

  // Idle knobs: each side draws an idle gap from 0 up to its max per request; a max
  // of 0 gives back-to-back traffic.
  int send_idle_max = IDLE_MAX;
  int recv_idle_max = IDLE_MAX;
  int recv_wait     = 0;
  int hold_cycles   = 0;

  function automatic int draw_idle(int max_cycles);
    return (max_cycles == 0) ? 0 : $urandom_range(0, max_cycles);
  endfunction

  // Clamp x to [lo, hi] and scale onto 0..65535, rounding half up, in exact
  // integer arithmetic. An empty or inverted range gives code 0.
  function automatic logic [CODE_W-1:0] quantize_code(logic signed [VAL_W-1:0] x, lo, hi);
    longint          xv, lv, hv;
    longint unsigned num, den, q;
    xv = x;
    lv = lo;
    hv = hi;
    if (hv <= lv) return '0;
    if (xv < lv) xv = lv;
    if (xv > hv) xv = hv;
    den = hv - lv;
    num = (xv - lv) * 65535;
    q   = (2 * num + den) / (2 * den);
    if (q > CODE_TOP) q = CODE_TOP;
    return q[CODE_W-1:0];
  endfunction

  function automatic logic is_calf_joint(logic [ID_W-1:0] id);
    return (id % JOINTS_PER_LEG) == CALF_JOINT;
  endfunction

  // Build the frame the block should send for one command under the current ranges.
  function automatic can_frame_t pack_command(motor_cmd_t c);
    logic signed [VAL_W-1:0] tlo, thi;
    logic [CODE_W-1:0]       tc;
    can_frame_t              f;
    if (is_calf_joint(c.id)) begin
      tlo = range_reg[REG_CALF_TORQUE_LOW];
      thi = range_reg[REG_CALF_TORQUE_HIGH];
    end else begin
      tlo = range_reg[REG_TORQUE_LOW];
      thi = range_reg[REG_TORQUE_HIGH];
    end
    tc = quantize_code(c.torque, tlo, thi);
    f.frame_id = {FRAME_MODE, tc, c.id};
    f.payload  = {quantize_code(c.pos, range_reg[REG_POS_LOW], range_reg[REG_POS_HIGH]),
                  quantize_code(c.vel, range_reg[REG_VEL_LOW], range_reg[REG_VEL_HIGH]),
                  quantize_code(c.stiff, STIFF_LO, STIFF_HI),
                  quantize_code(c.damp, DAMP_LO, DAMP_HI)};
    return f;
  endfunction

  function automatic motor_cmd_t make_cmd(logic signed [VAL_W-1:0] pos, vel, stiff, damp,
                                          torque, logic [ID_W-1:0] id);
    motor_cmd_t c;
    c.pos    = pos;
    c.vel    = vel;
    c.stiff  = stiff;
    c.damp   = damp;
    c.torque = torque;
    c.id     = id;
    return c;
  endfunction

  // Pick a value for a field with range [lo, hi]: often inside, often on or
  // just past an end, sometimes far outside or fully random.
  function automatic logic signed [VAL_W-1:0] draw_value(logic signed [VAL_W-1:0] lo, hi);
    longint          lv, hv;
    longint unsigned span, r;
    int              pick;
    lv   = lo;
    hv   = hi;
    r    = {$urandom, $urandom};
    pick = $urandom_range(0, 15);
    if (hv <= lv) return $urandom;
    span = hv - lv;
    case (pick)
      0, 1: return $urandom;
      2:    return lo;
      3:    return hi;
      4:    return VAL_W'(lv - 1);
      5:    return VAL_W'(hv + 1);
      6:    return Q_MIN;
      7:    return Q_MAX;
      8:    return VAL_W'(lv - longint'(r % (span / 4 + 1)));
      9:    return VAL_W'(hv + longint'(r % (span / 4 + 1)));
      default: return VAL_W'(lv + longint'(r % (span + 1)));
    endcase
  endfunction

  function automatic motor_cmd_t draw_command();
    motor_cmd_t c;
    case ($urandom_range(0, 3))
      0:       c.id = ID_W'(10 * $urandom_range(0, 25) + 3);
      default: c.id = ID_W'($urandom_range(0, 255));
    endcase
    c.pos   = draw_value(range_reg[REG_POS_LOW], range_reg[REG_POS_HIGH]);
    c.vel   = draw_value(range_reg[REG_VEL_LOW], range_reg[REG_VEL_HIGH]);
    c.stiff = draw_value(STIFF_LO, STIFF_HI);
    c.damp  = draw_value(DAMP_LO, DAMP_HI);
    if (is_calf_joint(c.id))
      c.torque = draw_value(range_reg[REG_CALF_TORQUE_LOW], range_reg[REG_CALF_TORQUE_HIGH]);
    else
      c.torque = draw_value(range_reg[REG_TORQUE_LOW], range_reg[REG_TORQUE_HIGH]);
    return c;
  endfunction

  // Offer one command request after a random gap; hold valid until accepted,
  // then queue its predicted frame. Valid stays high for a back-to-back follower.
  task automatic send_command(motor_cmd_t c);
    int gap;
    gap = draw_idle(send_idle_max);
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.pos_target     = c.pos;
    cmd_if.vel_target     = c.vel;
    cmd_if.stiffness_gain = c.stiff;
    cmd_if.damping_gain   = c.damp;
    cmd_if.torque_ff      = c.torque;
    cmd_if.actuator_id    = c.id;
    cmd_if.valid          = 1'b1;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_frames.push_back(pack_command(c));
    if (is_calf_joint(c.id)) n_calf++;
    n_sent++;
  endtask

  // Drop command valid, wait for every queued frame, then let the pipe run dry.
  task automatic wait_idle();
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic write_range_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    @(negedge clk_i);
    cfg_if.index = idx;
    cfg_if.data  = val;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    // Indexes past the register list are dropped by the block.
    if (idx < NUM_REGS) range_reg[idx[REG_IDX_W-1:0]] = val;
    n_cfg_writes++;
  endtask

  task automatic end_cfg();
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic program_pair(cfg_reg_e lo_reg, cfg_reg_e hi_reg,
                              logic signed [VAL_W-1:0] lo, hi);
    write_range_reg(lo_reg, lo);
    write_range_reg(hi_reg, hi);
  endtask

  task automatic draw_range(output logic signed [VAL_W-1:0] lo, hi);
    logic signed [VAL_W-1:0] a, b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 9))
      0: begin lo = a; hi = b; end
      1: begin lo = a; hi = a; end
      2: begin lo = Q_MIN; hi = Q_MAX; end
      3: begin
        lo = VAL_W'(int'($urandom_range(0, 2097152)) - 1048576);
        hi = lo + VAL_W'($urandom_range(1, 8));
      end
      4: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end
      5, 6: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
      default: begin
        lo = -VAL_W'($urandom_range(1, 16777216));
        hi = VAL_W'($urandom_range(1, 16777216));
      end
    endcase
  endtask

  // Frames come back in order; pop the oldest prediction for each one.
  always @(posedge clk_i) begin
    can_frame_t want;
    if (rst_ni) begin
      if (cmd_if.valid && !cmd_if.ready) n_in_stalls++;
      if (res_if.valid && res_if.ready) begin
        recv_wait = draw_idle(recv_idle_max);
        n_checked++;
        if (pending_frames.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected frame, expected none, actual frame_id %h payload %h",
                   $time, res_if.frame_id, res_if.payload);
        end else begin
          want = pending_frames.pop_front();
          if (res_if.frame_id !== want.frame_id) begin
            n_errors++;
            $display("%0t: frame_id mismatch, expected %h, actual %h",
                     $time, want.frame_id, res_if.frame_id);
          end
          if (res_if.payload !== want.payload) begin
            n_errors++;
            $display("%0t: payload mismatch, expected %h, actual %h",
                     $time, want.payload, res_if.payload);
          end
        end
      end
    end
  end

  // Result side: a long hold-off takes priority, else wait out the drawn gap.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      res_if.ready = 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      res_if.ready = 1'b0;
    end else begin
      res_if.ready = 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout after %0d cycles, %0d frames still pending",
             $time, CYCLE_LIMIT, pending_frames.size());
    $display("status: fail");
    $finish;
  end

  // Reset ranges: field extremes, exact range ends, calf and non-calf ids.
  task automatic test_reset_ranges();
    send_command(make_cmd('0, '0, '0, '0, '0, 8'd0));
    send_command(make_cmd(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 8'd255));
    send_command(make_cmd(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 8'd3));
    send_command(make_cmd(-32'sd823550, 32'sd2883584, STIFF_LO, DAMP_HI, 32'sd1114112, 8'd13));
    send_command(make_cmd(32'sd823550, -32'sd2883584, STIFF_HI, DAMP_LO, -32'sd1114112, 8'd10));
    send_command(make_cmd(-32'sd823549, 32'sd2883583, 32'sd1, 32'sd6553599, -32'sd1114111,
                          8'd253));
    send_command(make_cmd(32'sd823551, -32'sd2883585, -32'sd1, 32'sd6553601, 32'sd1114113,
                          8'd243));
    send_command(make_cmd(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                          32'sh5555_5555, 8'h55));
    send_command(make_cmd(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                          32'shAAAA_AAAA, 8'hAA));
    send_command(make_cmd(32'sd1000, -32'sd1000, 32'sd163840000, 32'sd3276800, 32'sd1, 8'd103));
    send_command(make_cmd(-32'sd1, 32'sd1, 32'sd327679999, 32'sd1, -32'sd1, 8'd4));
    send_command(make_cmd(32'sd411775, -32'sd1441792, 32'sd5000, 32'sd50, 32'sd557056, 8'd93));
  endtask

  // Full-span, inverted, empty and one-step ranges, plus writes to dead indexes.
  task automatic test_range_extremes();
    wait_idle();
    program_pair(REG_POS_LOW, REG_POS_HIGH, Q_MIN, Q_MAX);
    program_pair(REG_VEL_LOW, REG_VEL_HIGH, Q_MIN, Q_MAX);
    program_pair(REG_TORQUE_LOW, REG_TORQUE_HIGH, Q_MIN, Q_MAX);
    program_pair(REG_CALF_TORQUE_LOW, REG_CALF_TORQUE_HIGH, Q_MIN, Q_MAX);
    end_cfg();
    send_command(make_cmd(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, 8'd3));
    send_command(make_cmd('0, '0, '0, '0, '0, 8'd4));
    send_command(make_cmd(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, 8'd13));

    // Inverted and empty ranges must give code 0 whatever the value.
    wait_idle();
    program_pair(REG_POS_LOW, REG_POS_HIGH, Q_MAX, Q_MIN);
    program_pair(REG_VEL_LOW, REG_VEL_HIGH, 32'sd7, 32'sd7);
    program_pair(REG_TORQUE_LOW, REG_TORQUE_HIGH, '0, '0);
    program_pair(REG_CALF_TORQUE_LOW, REG_CALF_TORQUE_HIGH, 32'sd1, -32'sd1);
    end_cfg();
    send_command(make_cmd('0, 32'sd7, STIFF_HI, DAMP_HI, '0, 8'd5));
    send_command(make_cmd(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 8'd23));

    // Narrow ranges; position 1 in [0, 2] lands exactly on a half and rounds up.
    wait_idle();
    program_pair(REG_POS_LOW, REG_POS_HIGH, '0, 32'sd2);
    program_pair(REG_VEL_LOW, REG_VEL_HIGH, -32'sd1, '0);
    program_pair(REG_TORQUE_LOW, REG_TORQUE_HIGH, 32'sd5, 32'sd6);
    program_pair(REG_CALF_TORQUE_LOW, REG_CALF_TORQUE_HIGH, Q_MIN, '0);
    end_cfg();
    send_command(make_cmd(32'sd1, '0, 32'sd100, 32'sd100, 32'sd6, 8'd7));
    send_command(make_cmd(32'sd2, -32'sd1, 32'sd1, 32'sd1, -32'sd1073741824, 8'd33));

    // Writes past the register list must leave every range untouched.
    wait_idle();
    write_range_reg(CFG_IDX_W'(NUM_REGS), $urandom);
    write_range_reg(8'hFF, $urandom);
    write_range_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 255)), $urandom);
    end_cfg();
    send_command(make_cmd(32'sd1, '0, 32'sd100, 32'sd100, 32'sd5, 8'd8));
    send_command(make_cmd(32'sd2, -32'sd1, 32'sd1, 32'sd1, -32'sd7, 8'd63));
  endtask

  // Random ranges per phase, random commands, and a mix of idle and busy phases.
  task automatic test_random_traffic(int phases, int per_phase);
    logic signed [VAL_W-1:0] lo, hi;
    for (int p = 0; p < phases; p++) begin
      wait_idle();
      draw_range(lo, hi);
      program_pair(REG_POS_LOW, REG_POS_HIGH, lo, hi);
      draw_range(lo, hi);
      program_pair(REG_VEL_LOW, REG_VEL_HIGH, lo, hi);
      draw_range(lo, hi);
      program_pair(REG_TORQUE_LOW, REG_TORQUE_HIGH, lo, hi);
      draw_range(lo, hi);
      program_pair(REG_CALF_TORQUE_LOW, REG_CALF_TORQUE_HIGH, lo, hi);
      if ($urandom_range(0, 2) == 0)
        write_range_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 255)), $urandom);
      end_cfg();
      send_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
      recv_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
      for (int i = 0; i < per_phase; i++) send_command(draw_command());
    end
    send_idle_max = IDLE_MAX;
    recv_idle_max = IDLE_MAX;
  endtask

  // Hold the result side off while commands keep coming, so the pipe fills
  // and the command side stalls.
  task automatic test_backpressure(int count);
    wait_idle();
    send_idle_max = 0;
    @(posedge clk_i);
    hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < count; i++) send_command(draw_command());
    send_idle_max = IDLE_MAX;
  endtask

  initial begin
    cmd_if.valid          = 1'b0;
    cmd_if.pos_target     = '0;
    cmd_if.vel_target     = '0;
    cmd_if.stiffness_gain = '0;
    cmd_if.damping_gain   = '0;
    cmd_if.torque_ff      = '0;
    cmd_if.actuator_id    = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    res_if.ready          = 1'b0;

    // Reset ranges as the block should load them.
    range_reg[REG_POS_LOW]          = -32'sd823550;
    range_reg[REG_POS_HIGH]         = 32'sd823550;
    range_reg[REG_VEL_LOW]          = -32'sd2883584;
    range_reg[REG_VEL_HIGH]         = 32'sd2883584;
    range_reg[REG_TORQUE_LOW]       = -32'sd1114112;
    range_reg[REG_TORQUE_HIGH]      = 32'sd1114112;
    range_reg[REG_CALF_TORQUE_LOW]  = -32'sd1114112;
    range_reg[REG_CALF_TORQUE_HIGH] = 32'sd1114112;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_ranges();
    test_range_extremes();
    test_random_traffic(4, 100);
    test_backpressure(80);
    test_random_traffic(4, 100);

    // Drain, then watch a while longer for stray frames.
    wait_idle();
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);

    $display("sent %0d commands (%0d to calf joints) over %0d range writes; checked %0d frames",
             n_sent, n_calf, n_cfg_writes, n_checked);
    $display("command side stalled %0d cycles under result back-pressure; %0d mismatches",
             n_in_stalls, n_errors);
    if (n_errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
